@@ design/line_follow_cascade_pid_core_defines.svh @@
// ----------------------------------------------------------------------------
// line follow cascade pid core: assertion macros
// concurrent checks clocked on clk, with and without the reset guard
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_CASCADE_PID_CORE_DEFINES_SVH
`define LINE_FOLLOW_CASCADE_PID_CORE_DEFINES_SVH

// check that is switched off while rst_n is low
`define LFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also runs through reset
`define LFC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/lfc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfc_pkg
// shared types and fixed constants of the line follow cascade pid core
// ----------------------------------------------------------------------------
`default_nettype none

package lfc_pkg;

  // field and register widths
  localparam int GAIN_W     = 12;
  localparam int BASE_W     = 8;
  localparam int LINE_W     = 8;
  localparam int SUM_W      = 24;
  localparam int TARGET_W   = 16;
  localparam int DRIVE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_KP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_KI   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_KD   = 3'd6;

  // wheel gain reset values
  localparam logic [GAIN_W-1:0] RST_WHEEL_KP = 12'd435;
  localparam logic [GAIN_W-1:0] RST_WHEEL_KI = 12'd256;
  localparam logic [GAIN_W-1:0] RST_WHEEL_KD = 12'd0;

  // operation codes
  localparam logic OP_STEER = 1'b0;
  localparam logic OP_WHEEL = 1'b1;

  // limits and forced targets, whole units
  localparam int OFF_LINE_ERR    = 100;
  localparam int LIM_STEER_INTEG = 20;
  localparam int LIM_STEER_OUT   = 60;
  localparam int LIM_TARGET      = 65;
  localparam int LIM_WHEEL_INTEG = 100;
  localparam int LIM_DRIVE       = 100;
  localparam int FORCE_NEAR      = 30;
  localparam int FORCE_FAR       = -20;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } wheel_gain_t;

endpackage

`default_nettype wire

@@ design/line_follow_cascade_pid_core.sv @@
// ----------------------------------------------------------------------------
// line_follow_cascade_pid_core: cascaded steering and wheel speed pid
// a request passes the input reg, then the result reg, on its way to result valid
// one request per cycle while out_stall is low; one pid pass between the two regs
// rst_n (sync, low) empties both stages, zeroes pid state, reloads gain defaults
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_follow_cascade_pid_core_defines.svh"

module line_follow_cascade_pid_core #(
  parameter int FRAC_BITS  = 8,
  parameter int SPEED_BITS = 11
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lfc_pkg::CFG_DATA_W-1:0]        cfg_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic signed [lfc_pkg::LINE_W-1:0]     in_line_error,
  input  logic signed [SPEED_BITS-1:0]          in_left_speed,
  input  logic signed [SPEED_BITS-1:0]          in_right_speed,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lfc_pkg::TARGET_W-1:0]   out_left_setpoint,
  output logic signed [lfc_pkg::TARGET_W-1:0]   out_right_setpoint,
  output logic signed [lfc_pkg::DRIVE_W-1:0]    out_left_drive,
  output logic signed [lfc_pkg::DRIVE_W-1:0]    out_right_drive,
  output logic                                  out_off_line
);

  // widths that follow the fraction and speed widths
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int GW   = FRAC_BITS + 8;               // wheel target
  localparam int IW   = FRAC_BITS + 8;               // wheel integral
  localparam int EW   = SPEED_BITS + FRAC_BITS + 1;  // wheel error
  localparam int KW   = lfc_pkg::GAIN_W + 1;         // gain as signed
  localparam int LW   = lfc_pkg::LINE_W;
  localparam int SW   = lfc_pkg::SUM_W;
  localparam int IPW  = FRAC_BITS + 6;               // clamped steer integral term
  localparam int PIDW = FRAC_BITS + 7;               // clamped steer correction

  localparam int STEER_I_LIM = lfc_pkg::LIM_STEER_INTEG * ONE;
  localparam int STEER_O_LIM = lfc_pkg::LIM_STEER_OUT * ONE;
  localparam int TGT_LIM     = lfc_pkg::LIM_TARGET * ONE;
  localparam int WHL_I_LIM   = lfc_pkg::LIM_WHEEL_INTEG * ONE;

  localparam logic signed [GW-1:0] GOAL_NEAR = GW'(lfc_pkg::FORCE_NEAR * ONE);
  localparam logic signed [GW-1:0] GOAL_FAR  = GW'(lfc_pkg::FORCE_FAR * ONE);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [lfc_pkg::GAIN_W-1:0]        steer_kp_r, steer_ki_r, steer_kd_r;
  logic signed [lfc_pkg::BASE_W-1:0] base_speed_r;
  lfc_pkg::wheel_gain_t              wheel_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_kp_r      <= '0;
      steer_ki_r      <= '0;
      steer_kd_r      <= '0;
      base_speed_r    <= '0;
      wheel_gain_r.kp <= lfc_pkg::RST_WHEEL_KP;
      wheel_gain_r.ki <= lfc_pkg::RST_WHEEL_KI;
      wheel_gain_r.kd <= lfc_pkg::RST_WHEEL_KD;
    end else if (cfg_we) begin
      case (cfg_index)
        lfc_pkg::REG_STEER_KP:   steer_kp_r      <= cfg_data[lfc_pkg::GAIN_W-1:0];
        lfc_pkg::REG_STEER_KI:   steer_ki_r      <= cfg_data[lfc_pkg::GAIN_W-1:0];
        lfc_pkg::REG_STEER_KD:   steer_kd_r      <= cfg_data[lfc_pkg::GAIN_W-1:0];
        lfc_pkg::REG_BASE_SPEED: base_speed_r    <= cfg_data[lfc_pkg::BASE_W-1:0];
        lfc_pkg::REG_WHEEL_KP:   wheel_gain_r.kp <= cfg_data[lfc_pkg::GAIN_W-1:0];
        lfc_pkg::REG_WHEEL_KI:   wheel_gain_r.ki <= cfg_data[lfc_pkg::GAIN_W-1:0];
        lfc_pkg::REG_WHEEL_KD:   wheel_gain_r.kd <= cfg_data[lfc_pkg::GAIN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: input stage moves into the result reg when that reg is free
  // or being drained in the same cycle
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;

  assign advance   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~advance;
  assign out_valid = out_valid_r;

  logic                          s1_op_r;
  logic signed [LW-1:0]          s1_line_err_r;
  logic signed [SPEED_BITS-1:0]  s1_left_speed_r, s1_right_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload is captured only on accept, so a held request stays put
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r          <= in_operation;
      s1_line_err_r    <= in_line_error;
      s1_left_speed_r  <= in_left_speed;
      s1_right_speed_r <= in_right_speed;
    end
  end

  // --------------------------------------------------------------------------
  // controller state
  // --------------------------------------------------------------------------
  logic signed [LW-1:0]               prev_err_r,    prev_err_nxt;
  logic signed [SW-1:0]               err_sum_r,     err_sum_nxt;
  logic signed [GW-1:0]               left_goal_r,   left_goal_nxt;
  logic signed [GW-1:0]               right_goal_r,  right_goal_nxt;
  logic signed [IW-1:0]               left_integ_r,  left_integ_nxt;
  logic signed [IW-1:0]               right_integ_r, right_integ_nxt;
  logic signed [EW-1:0]               left_last_r,   left_last_nxt;
  logic signed [EW-1:0]               right_last_r,  right_last_nxt;
  logic signed [lfc_pkg::DRIVE_W-1:0] left_drive_r,  left_drive_nxt;
  logic signed [lfc_pkg::DRIVE_W-1:0] right_drive_r, right_drive_nxt;
  logic                               off_line_r,    off_line_nxt;

  // --------------------------------------------------------------------------
  // steering pid
  // --------------------------------------------------------------------------
  logic signed [KW-1:0]      st_kp_s, st_ki_s, st_kd_s;
  logic signed [SW:0]        sum_wide;
  logic signed [SW-1:0]      sum_sat;
  logic signed [SW+KW-1:0]   ip_raw;
  logic signed [IPW-1:0]     ip_term;
  logic signed [KW+LW-1:0]   p_term;
  logic signed [LW:0]        line_diff;
  logic signed [KW+LW:0]     d_term;
  logic signed [KW+LW+2:0]   pid_raw;
  logic signed [PIDW-1:0]    pid;
  logic signed [GW-1:0]      base_sh;
  logic signed [GW:0]        lt_raw, rt_raw;
  logic signed [GW-1:0]      lt_pid, rt_pid;
  logic                      at_pos_edge, at_neg_edge;

  assign st_kp_s = $signed({1'b0, steer_kp_r});
  assign st_ki_s = $signed({1'b0, steer_ki_r});
  assign st_kd_s = $signed({1'b0, steer_kd_r});

  // off-line sentinels, exactly plus or minus OFF_LINE_ERR (100), not full scale
  assign at_pos_edge = (s1_line_err_r == lfc_pkg::OFF_LINE_ERR);
  assign at_neg_edge = (s1_line_err_r == -lfc_pkg::OFF_LINE_ERR);

  // running error sum saturates at the 24 bit signed range
  assign sum_wide = (SW+1)'(err_sum_r) + (SW+1)'(s1_line_err_r);

  always_comb begin
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
  end

  assign ip_raw = st_ki_s * sum_sat;

  always_comb begin
    if (ip_raw > STEER_I_LIM) begin
      ip_term = IPW'(STEER_I_LIM);
    end else if (ip_raw < -STEER_I_LIM) begin
      ip_term = IPW'(-STEER_I_LIM);
    end else begin
      ip_term = IPW'(ip_raw);
    end
  end

  assign p_term    = st_kp_s * s1_line_err_r;
  assign line_diff = (LW+1)'(s1_line_err_r) - (LW+1)'(prev_err_r);
  assign d_term    = st_kd_s * line_diff;
  assign pid_raw   = (KW+LW+3)'(p_term) + (KW+LW+3)'(ip_term) + (KW+LW+3)'(d_term);

  always_comb begin
    if (pid_raw > STEER_O_LIM) begin
      pid = PIDW'(STEER_O_LIM);
    end else if (pid_raw < -STEER_O_LIM) begin
      pid = PIDW'(-STEER_O_LIM);
    end else begin
      pid = PIDW'(pid_raw);
    end
  end

  // differential split around the base speed
  assign base_sh = GW'(base_speed_r) <<< FRAC_BITS;
  assign lt_raw  = (GW+1)'(base_sh) + (GW+1)'(pid);
  assign rt_raw  = (GW+1)'(base_sh) - (GW+1)'(pid);

  always_comb begin
    if (lt_raw > TGT_LIM) begin
      lt_pid = GW'(TGT_LIM);
    end else if (lt_raw < -TGT_LIM) begin
      lt_pid = GW'(-TGT_LIM);
    end else begin
      lt_pid = GW'(lt_raw);
    end
    if (rt_raw > TGT_LIM) begin
      rt_pid = GW'(TGT_LIM);
    end else if (rt_raw < -TGT_LIM) begin
      rt_pid = GW'(-TGT_LIM);
    end else begin
      rt_pid = GW'(rt_raw);
    end
  end

  // --------------------------------------------------------------------------
  // wheel speed pids, one per side
  // --------------------------------------------------------------------------
  logic signed [IW-1:0]               wl_integ, wr_integ;
  logic signed [EW-1:0]               wl_err, wr_err;
  logic signed [lfc_pkg::DRIVE_W-1:0] wl_drive, wr_drive;

  lfc_wheel_pid #(
    .FRAC_BITS  (FRAC_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_left_pid (
    .gain      (wheel_gain_r),
    .goal      (left_goal_r),
    .speed     (s1_left_speed_r),
    .integ     (left_integ_r),
    .last_err  (left_last_r),
    .integ_nxt (wl_integ),
    .err       (wl_err),
    .drive     (wl_drive)
  );

  lfc_wheel_pid #(
    .FRAC_BITS  (FRAC_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_right_pid (
    .gain      (wheel_gain_r),
    .goal      (right_goal_r),
    .speed     (s1_right_speed_r),
    .integ     (right_integ_r),
    .last_err  (right_last_r),
    .integ_nxt (wr_integ),
    .err       (wr_err),
    .drive     (wr_drive)
  );

  // --------------------------------------------------------------------------
  // state update, only when the request leaves the input stage
  // --------------------------------------------------------------------------
  always_comb begin
    prev_err_nxt    = prev_err_r;
    err_sum_nxt     = err_sum_r;
    left_goal_nxt   = left_goal_r;
    right_goal_nxt  = right_goal_r;
    left_integ_nxt  = left_integ_r;
    right_integ_nxt = right_integ_r;
    left_last_nxt   = left_last_r;
    right_last_nxt  = right_last_r;
    left_drive_nxt  = left_drive_r;
    right_drive_nxt = right_drive_r;
    off_line_nxt    = off_line_r;
    if (advance) begin
      case (s1_op_r)
        lfc_pkg::OP_STEER: begin
          prev_err_nxt = s1_line_err_r;
          if (at_pos_edge) begin
            // line lost to one side: hard turn, sum frozen
            left_goal_nxt  = GOAL_NEAR;
            right_goal_nxt = GOAL_FAR;
            off_line_nxt   = 1'b1;
          end else if (at_neg_edge) begin
            left_goal_nxt  = GOAL_FAR;
            right_goal_nxt = GOAL_NEAR;
            off_line_nxt   = 1'b1;
          end else begin
            err_sum_nxt    = sum_sat;
            left_goal_nxt  = lt_pid;
            right_goal_nxt = rt_pid;
            off_line_nxt   = 1'b0;
          end
        end
        lfc_pkg::OP_WHEEL: begin
          left_integ_nxt  = wl_integ;
          right_integ_nxt = wr_integ;
          left_last_nxt   = wl_err;
          right_last_nxt  = wr_err;
          left_drive_nxt  = wl_drive;
          right_drive_nxt = wr_drive;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r    <= '0;
      err_sum_r     <= '0;
      left_goal_r   <= '0;
      right_goal_r  <= '0;
      left_integ_r  <= '0;
      right_integ_r <= '0;
      left_last_r   <= '0;
      right_last_r  <= '0;
      left_drive_r  <= '0;
      right_drive_r <= '0;
      off_line_r    <= 1'b0;
    end else begin
      prev_err_r    <= prev_err_nxt;
      err_sum_r     <= err_sum_nxt;
      left_goal_r   <= left_goal_nxt;
      right_goal_r  <= right_goal_nxt;
      left_integ_r  <= left_integ_nxt;
      right_integ_r <= right_integ_nxt;
      left_last_r   <= left_last_nxt;
      right_last_r  <= right_last_nxt;
      left_drive_r  <= left_drive_nxt;
      right_drive_r <= right_drive_nxt;
      off_line_r    <= off_line_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic signed [lfc_pkg::TARGET_W-1:0] out_left_setpoint_r, out_right_setpoint_r;
  logic signed [lfc_pkg::DRIVE_W-1:0]  out_left_drive_r, out_right_drive_r;
  logic                                out_off_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // targets wrap into the 16 bit field when the fraction is wide
  always_ff @(posedge clk) begin
    if (advance) begin
      out_left_setpoint_r  <= lfc_pkg::TARGET_W'(left_goal_nxt);
      out_right_setpoint_r <= lfc_pkg::TARGET_W'(right_goal_nxt);
      out_left_drive_r     <= left_drive_nxt;
      out_right_drive_r    <= right_drive_nxt;
      out_off_line_r       <= off_line_nxt;
    end
  end

  assign out_left_setpoint  = out_left_setpoint_r;
  assign out_right_setpoint = out_right_setpoint_r;
  assign out_left_drive     = out_left_drive_r;
  assign out_right_drive    = out_right_drive_r;
  assign out_off_line       = out_off_line_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `LFC_ASSERT(a_off_line_goals,
    off_line_r |-> ((left_goal_r == GOAL_NEAR && right_goal_r == GOAL_FAR) ||
                    (left_goal_r == GOAL_FAR && right_goal_r == GOAL_NEAR)),
    "off-line flag without forced targets")
  `LFC_ASSERT(a_goal_range,
    left_goal_r <= TGT_LIM && left_goal_r >= -TGT_LIM &&
    right_goal_r <= TGT_LIM && right_goal_r >= -TGT_LIM,
    "wheel target outside limit")
  `LFC_ASSERT(a_integ_range,
    left_integ_r <= WHL_I_LIM && left_integ_r >= -WHL_I_LIM &&
    right_integ_r <= WHL_I_LIM && right_integ_r >= -WHL_I_LIM,
    "wheel integral outside limit")
  `LFC_ASSERT(a_drive_range,
    left_drive_r <= lfc_pkg::LIM_DRIVE && left_drive_r >= -lfc_pkg::LIM_DRIVE &&
    right_drive_r <= lfc_pkg::LIM_DRIVE && right_drive_r >= -lfc_pkg::LIM_DRIVE,
    "drive outside percent range")
  `LFC_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid_r && !s1_valid_r),
    "pipeline not empty after reset")

endmodule

`default_nettype wire

@@ design/lfc_wheel_pid.sv @@
// ----------------------------------------------------------------------------
// lfc_wheel_pid
// one wheel speed pid: error, clamped integral and drive percent
// ----------------------------------------------------------------------------
`default_nettype none

module lfc_wheel_pid #(
  parameter int FRAC_BITS  = 8,
  parameter int SPEED_BITS = 11
) (
  input  lfc_pkg::wheel_gain_t                       gain,
  input  logic signed [FRAC_BITS+7:0]                goal,
  input  logic signed [SPEED_BITS-1:0]               speed,
  input  logic signed [FRAC_BITS+7:0]                integ,
  input  logic signed [SPEED_BITS+FRAC_BITS:0]       last_err,
  output logic signed [FRAC_BITS+7:0]                integ_nxt,
  output logic signed [SPEED_BITS+FRAC_BITS:0]       err,
  output logic signed [lfc_pkg::DRIVE_W-1:0]         drive
);

  localparam int EW   = SPEED_BITS + FRAC_BITS + 1;
  localparam int IW   = FRAC_BITS + 8;
  localparam int KW   = lfc_pkg::GAIN_W + 1;
  localparam int DW   = EW + KW + 3;
  localparam int CW   = 2 * FRAC_BITS + 8;
  localparam int ILIM = lfc_pkg::LIM_WHEEL_INTEG * (1 << FRAC_BITS);
  localparam int DLIM = lfc_pkg::LIM_DRIVE * (1 << (2 * FRAC_BITS));
  localparam int RND  = (1 << (2 * FRAC_BITS)) - 1;

  logic signed [KW-1:0]    kp_s, ki_s, kd_s;
  logic signed [EW:0]      isum;
  logic signed [EW:0]      ediff;
  logic signed [KW+EW-1:0] pterm;
  logic signed [KW+IW-1:0] iterm;
  logic signed [KW+EW:0]   dterm;
  logic signed [DW-1:0]    dsum;
  logic signed [CW-1:0]    dclamp;
  logic signed [CW-1:0]    dbias;

  assign kp_s = $signed({1'b0, gain.kp});
  assign ki_s = $signed({1'b0, gain.ki});
  assign kd_s = $signed({1'b0, gain.kd});

  assign err  = EW'(goal) - (EW'(speed) <<< FRAC_BITS);
  assign isum = (EW+1)'(integ) + (EW+1)'(err);

  always_comb begin
    if (isum > ILIM) begin
      integ_nxt = IW'(ILIM);
    end else if (isum < -ILIM) begin
      integ_nxt = IW'(-ILIM);
    end else begin
      integ_nxt = IW'(isum);
    end
  end

  assign ediff = (EW+1)'(err) - (EW+1)'(last_err);
  assign pterm = kp_s * err;
  assign iterm = ki_s * integ_nxt;
  assign dterm = kd_s * ediff;
  assign dsum  = DW'(pterm) + DW'(iterm) + DW'(dterm);

  always_comb begin
    if (dsum > DLIM) begin
      dclamp = CW'(DLIM);
    end else if (dsum < -DLIM) begin
      dclamp = CW'(-DLIM);
    end else begin
      dclamp = CW'(dsum);
    end
  end

  // bias negatives so the shift rounds toward zero
  assign dbias = dclamp + (dclamp[CW-1] ? CW'(RND) : CW'(0));
  assign drive = lfc_pkg::DRIVE_W'(dbias >>> (2 * FRAC_BITS));

endmodule

`default_nettype wire
